/* rtl/core/bus_frame_receiver_crc16_unit_defines.svh */
// Assertion macros shared by the frame receiver RTL.
`ifndef BUS_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH
`define BUS_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define BFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define BFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFR_ASSERT_IMPL(label, ante, cons, msg)
`define BFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/bfr_crc16_pkg.sv */
// Package with the frame constants and phase type of the frame receiver.
`default_nettype none

package bfr_crc16_pkg;

    // Start byte codes.
    localparam logic [7:0] START_REQUEST  = 8'h3F;
    localparam logic [7:0] START_RESPONSE = 8'h2A;

    // CRC-16/MODBUS parameters (reflected form).
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame assembly phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_ADDR  = 7'b0000100,
        PH_FUNC  = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_CRCH  = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

endpackage

`default_nettype wire

/* rtl/core/bfr_crc16_step.sv */
// Folds one byte into a running CRC-16/MODBUS value.
`default_nettype none

module bfr_crc16_step
    import bfr_crc16_pkg::*;
(
    input  wire logic [15:0] seed,
    input  wire logic [7:0]  rx_data,
    output logic [15:0]      folded
);

    // Eight bit steps of the reflected shift register.
    always_comb
    begin
        logic [15:0] c;
        c = seed ^ {8'h00, rx_data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        folded = c;
    end

endmodule

`default_nettype wire

/* rtl/core/bus_frame_receiver_crc16_unit.sv */
// Top level of the six-byte serial frame receiver with CRC-16/MODBUS check.
//
// Usage: received bytes enter on the input channel (in_valid, in_stall, rx_byte).
// A frame is a start byte (0x3F request or 0x2A response), address, function,
// data, CRC high byte and CRC low byte. Either start byte restarts the frame
// at any position. Bytes before a start byte or after a complete frame are
// dropped. The CRC low byte of a frame makes one request on the output
// channel (out_valid, out_stall) carrying the frame fields and crc_ok.
// Path: an accepted byte is held in the input register, then folded into the
// frame state and, for the CRC low byte, into the result register.
// Throughput: one byte per cycle while no result is stalled, as the CRC byte
// fold between the input register and the running CRC register is combinational.
// Reset clears the frame phase, the running CRC and both valid flags.
// When the receiver stalls a result, the result stays put, one more byte is
// held in the input register, and in_stall rises only when that register is
// also full.
`default_nettype none

`include "bus_frame_receiver_crc16_unit_defines.svh"

module bus_frame_receiver_crc16_unit
    import bfr_crc16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_response,
    output logic [7:0]       node_address,
    output logic [7:0]       function_code,
    output logic [7:0]       payload,
    output logic [15:0]      received_crc,
    output logic             crc_ok
);

    // Input register.
    logic        in_v_reg, in_v_next;
    logic [7:0]  in_byte_reg, in_byte_next;

    // Frame state.
    phase_t      phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  crch_reg, crch_next;
    logic [15:0] crc_reg, crc_next;

    // Result register.
    logic        out_v_reg, out_v_next;
    logic        res_kind_reg, res_kind_next;
    logic [7:0]  res_addr_reg, res_addr_next;
    logic [7:0]  res_func_reg, res_func_next;
    logic [7:0]  res_data_reg, res_data_next;
    logic [15:0] res_crc_reg, res_crc_next;
    logic        res_ok_reg, res_ok_next;

    logic        advance;
    logic        take_in;
    logic        process;
    logic        is_start;
    logic        emit;
    logic [15:0] crc_seed;
    logic [15:0] crc_folded;
    logic [15:0] rx_crc;

    // Pipeline moves when the result register is empty or being taken.
    assign advance  = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !advance;
    assign take_in  = in_valid && !in_stall;
    assign process  = in_v_reg && advance;

    assign is_start = (in_byte_reg == START_REQUEST) || (in_byte_reg == START_RESPONSE);
    assign crc_seed = is_start ? CRC_INIT : crc_reg;
    assign rx_crc   = {crch_reg, in_byte_reg};

    bfr_crc16_step u_crc_step (
        .seed    (crc_seed),
        .rx_data (in_byte_reg),
        .folded  (crc_folded)
    );

    // Input register load.
    always_comb
    begin
        in_v_next    = in_v_reg;
        in_byte_next = in_byte_reg;
        if (take_in)
        begin
            in_v_next    = 1'b1;
            in_byte_next = rx_byte;
        end
        else if (advance)
        begin
            in_v_next = 1'b0;
        end
    end

    // Frame assembly.
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        data_next  = data_reg;
        crch_next  = crch_reg;
        crc_next   = crc_reg;
        emit       = 1'b0;
        if (process)
        begin
            if (is_start)
            begin
                kind_next  = (in_byte_reg == START_RESPONSE);
                crc_next   = crc_folded;
                phase_next = PH_START;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        addr_next  = in_byte_reg;
                        crc_next   = crc_folded;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        func_next  = in_byte_reg;
                        crc_next   = crc_folded;
                        phase_next = PH_FUNC;
                    end
                    PH_FUNC:
                    begin
                        data_next  = in_byte_reg;
                        crc_next   = crc_folded;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        crch_next  = in_byte_reg;
                        phase_next = PH_CRCH;
                    end
                    PH_CRCH:
                    begin
                        emit       = 1'b1;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result register load.
    always_comb
    begin
        out_v_next    = out_v_reg;
        res_kind_next = res_kind_reg;
        res_addr_next = res_addr_reg;
        res_func_next = res_func_reg;
        res_data_next = res_data_reg;
        res_crc_next  = res_crc_reg;
        res_ok_next   = res_ok_reg;
        if (advance)
        begin
            out_v_next = emit;
        end
        if (emit)
        begin
            res_kind_next = kind_reg;
            res_addr_next = addr_reg;
            res_func_next = func_reg;
            res_data_next = data_reg;
            res_crc_next  = rx_crc;
            res_ok_next   = (rx_crc == crc_reg);
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            kind_reg  <= 1'b0;
            addr_reg  <= 8'h00;
            func_reg  <= 8'h00;
            data_reg  <= 8'h00;
            crch_reg  <= 8'h00;
            crc_reg   <= CRC_INIT;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            data_reg  <= data_next;
            crch_reg  <= crch_next;
            crc_reg   <= crc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        res_kind_reg <= res_kind_next;
        res_addr_reg <= res_addr_next;
        res_func_reg <= res_func_next;
        res_data_reg <= res_data_next;
        res_crc_reg  <= res_crc_next;
        res_ok_reg   <= res_ok_next;
    end

    assign out_valid     = out_v_reg;
    assign is_response   = res_kind_reg;
    assign node_address  = res_addr_reg;
    assign function_code = res_func_reg;
    assign payload       = res_data_reg;
    assign received_crc  = res_crc_reg;
    assign crc_ok        = res_ok_reg;

    // A result is always followed by the frame being marked complete.
    `BFR_ASSERT_NEXT(a_emit_done, emit,
        (phase_reg == PH_DONE) && out_v_reg, "frame result lost")
    // Backpressure reaches the input only with a byte held in the input register.
    `BFR_ASSERT_IMPL(a_stall_held, in_stall, in_v_reg && out_v_reg, "input stalled without cause")
    // A non-start byte while idle leaves the receiver idle.
    `BFR_ASSERT_NEXT(a_idle_ignore, process && !is_start && (phase_reg == PH_IDLE),
        (phase_reg == PH_IDLE) && !out_v_reg, "stray byte left idle")

endmodule

`default_nettype wire
